FILE: hw/rtl/lpq_pkg.sv
package lpq_pkg;

   localparam int DEF_NUM_LOCKS = 16;
   localparam int DEF_NUM_PROCS = 32;

   typedef enum logic [2:0] {
      ACT_ALLOC   = 3'd0,
      ACT_FREE    = 3'd1,
      ACT_WAIT    = 3'd2,
      ACT_TWAIT   = 3'd3,
      ACT_RELEASE = 3'd4,
      ACT_CANCEL  = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NO_LOCK     = 3'd1,
      ST_INVALID     = 3'd2,
      ST_HAS_WAITERS = 3'd3,
      ST_TIMED_OUT   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_APP_Q,
      S_APP_P,
      S_REL_Q,
      S_REL_P,
      S_CAN_TW,
      S_CAN_Q,
      S_CAN_WALK,
      S_CAN_FIX,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] granted_lock;
      logic       ready_valid;
      logic [4:0] ready_process;
      logic       cancel_timer;
   } res_type;

endpackage

FILE: hw/rtl/lpq_req_if.sv
interface lpq_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] lock_index;
   logic [4:0] process_id;

   modport source (output valid, output action, output lock_index, output process_id,
                   input ready);
   modport sink (input valid, input action, input lock_index, input process_id,
                 output ready);
endinterface

FILE: hw/rtl/lpq_rsp_if.sv
interface lpq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [3:0] granted_lock;
   logic       ready_valid;
   logic [4:0] ready_process;
   logic       cancel_timer;

   modport source (output valid, output status, output granted_lock, output ready_valid,
                   output ready_process, output cancel_timer, input ready);
   modport sink (input valid, input status, input granted_lock, input ready_valid,
                 input ready_process, input cancel_timer, output ready);
endinterface

FILE: hw/rtl/lock_pool_fifo_wait_queues.sv
// lock pool with fifo wait queues, one action per request beat
// a timeout cancel walks the lock's queue, one pmem read per waiter, and this walk
// over the next-waiter memory sets the worst case; only one action is in flight at a time
// reset: synchronous, all locks free, all queues empty, no timed waits, no response pending
module lock_pool_fifo_wait_queues
   import lpq_pkg::*;
#(
   parameter int NUM_LOCKS = DEF_NUM_LOCKS,
   parameter int NUM_PROCS = DEF_NUM_PROCS
) (
   input  logic         clock,
   input  logic         reset,
   lpq_req_if.sink      req_bus,
   lpq_rsp_if.source    rsp_bus
);

   localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int PW = $clog2(NUM_PROCS);
   localparam int PE = 1 + PW + LW;   // pmem entry: next valid, next, timed-wait lock

   // control state
   state_type              state_ff, state_in;
   logic [NUM_LOCKS-1:0]   in_use_ff, in_use_in;
   logic [NUM_LOCKS-1:0]   nonempty_ff, nonempty_in;
   logic [NUM_PROCS-1:0]   tw_valid_ff, tw_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [2:0]             act_ff;
   logic [7:0]             lk_ff;
   logic [4:0]             p_ff;
   logic [LW-1:0]          loc_ff, loc_in;
   logic [PW-1:0]          cur_ff, cur_in;
   logic [PW-1:0]          steps_ff, steps_in;
   logic [PW:0]            pnx_ff, pnx_in;     // saved next link of the cancelled process
   logic [LW-1:0]          ptw_ff, ptw_in;     // saved timed-wait lock of that process
   res_type                res_ff, res_in;
   res_type                rsp_ff;

   // queue memory: head and tail per lock
   logic [2*PW-1:0]        q_mem [NUM_LOCKS];
   logic [2*PW-1:0]        q_rd_ff;
   logic                   q_re, q_we;
   logic [LW-1:0]          q_raddr, q_waddr;
   logic [2*PW-1:0]        q_wdata;

   // process memory: next waiter link and timed-wait lock per process
   logic [PE-1:0]          p_mem [NUM_PROCS];
   logic [PE-1:0]          p_rd_ff;
   logic                   p_re, p_we;
   logic [PW-1:0]          p_raddr, p_waddr;
   logic [PE-1:0]          p_wdata;

   logic                   free_found;
   logic [LW-1:0]          free_index;
   logic                   req_beat, rsp_free;

   lpq_find_free #(
      .NUM_LOCKS (NUM_LOCKS),
      .LW        (LW)
   ) u_find_free (
      .in_use (in_use_ff),
      .found  (free_found),
      .index  (free_index)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // memories
   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      if (q_re) q_rd_ff <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (p_we) p_mem[p_waddr] <= p_wdata;
      if (p_re) p_rd_ff <= p_mem[p_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= '0;
         nonempty_ff  <= '0;
         tw_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         nonempty_ff  <= nonempty_in;
         tw_valid_ff  <= tw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         act_ff <= req_bus.action;
         lk_ff  <= req_bus.lock_index;
         p_ff   <= req_bus.process_id;
      end
      loc_ff   <= loc_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      pnx_ff   <= pnx_in;
      ptw_ff   <= ptw_in;
      res_ff   <= res_in;
      if (state_ff == S_DONE && rsp_free) rsp_ff <= res_ff;
   end

   // sequencer
   always_comb begin
      logic          lock_ok;
      logic          proc_ok;
      logic [LW-1:0] li;
      logic [PW-1:0] pi;
      logic [PW-1:0] q_head, q_tail;
      logic          rd_nxv;
      logic [PW-1:0] rd_nx;
      logic [LW-1:0] rd_tw;

      li      = lk_ff[LW-1:0];
      pi      = PW'(p_ff);
      lock_ok = ({1'b0, lk_ff} < 9'(NUM_LOCKS)) && in_use_ff[li];
      proc_ok = (32'(p_ff) < NUM_PROCS);
      q_head  = q_rd_ff[2*PW-1:PW];
      q_tail  = q_rd_ff[PW-1:0];
      rd_nxv  = p_rd_ff[PE-1];
      rd_nx   = p_rd_ff[PE-2:LW];
      rd_tw   = p_rd_ff[LW-1:0];

      state_in     = state_ff;
      in_use_in    = in_use_ff;
      nonempty_in  = nonempty_ff;
      tw_valid_in  = tw_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      loc_in       = loc_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      pnx_in       = pnx_ff;
      ptw_in       = ptw_ff;
      res_in       = res_ff;
      q_re = 1'b0; q_raddr = loc_ff; q_we = 1'b0; q_waddr = loc_ff; q_wdata = '0;
      p_re = 1'b0; p_raddr = cur_ff; p_we = 1'b0; p_waddr = cur_ff; p_wdata = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) state_in = S_DECODE;
         end

         S_DECODE: begin
            res_in        = '0;
            res_in.status = ST_INVALID;
            loc_in        = li;
            state_in      = S_DONE;
            priority case (act_ff)
               ACT_ALLOC: begin
                  if (free_found) begin
                     in_use_in[free_index]   = 1'b1;
                     nonempty_in[free_index] = 1'b0;
                     res_in.status           = ST_OK;
                     res_in.granted_lock     = 4'(free_index);
                  end else begin
                     res_in.status = ST_NO_LOCK;
                  end
               end
               ACT_FREE: begin
                  if (lock_ok) begin
                     if (nonempty_ff[li]) begin
                        res_in.status = ST_HAS_WAITERS;
                     end else begin
                        in_use_in[li] = 1'b0;
                        res_in.status = ST_OK;
                     end
                  end
               end
               ACT_WAIT, ACT_TWAIT: begin
                  if (lock_ok && proc_ok) begin
                     // new waiter ends its own chain
                     p_we            = 1'b1;
                     p_waddr         = pi;
                     p_wdata         = {1'b0, {PW{1'b0}}, li};
                     tw_valid_in[pi] = (act_ff == ACT_TWAIT);
                     res_in.status   = ST_OK;
                     if (!nonempty_ff[li]) begin
                        nonempty_in[li] = 1'b1;
                        q_we            = 1'b1;
                        q_waddr         = li;
                        q_wdata         = {pi, pi};
                     end else begin
                        q_re     = 1'b1;
                        q_raddr  = li;
                        state_in = S_APP_Q;
                     end
                  end
               end
               ACT_RELEASE: begin
                  if (lock_ok) begin
                     res_in.status = ST_OK;
                     if (nonempty_ff[li]) begin
                        q_re     = 1'b1;
                        q_raddr  = li;
                        state_in = S_REL_Q;
                     end
                  end
               end
               ACT_CANCEL: begin
                  if (proc_ok && tw_valid_ff[pi]) begin
                     tw_valid_in[pi]      = 1'b0;
                     res_in.status        = ST_TIMED_OUT;
                     res_in.ready_valid   = 1'b1;
                     res_in.ready_process = p_ff;
                     p_re                 = 1'b1;
                     p_raddr              = pi;
                     state_in             = S_CAN_TW;
                  end
               end
               default: ;
            endcase
         end

         // append behind the current tail
         S_APP_Q: begin
            q_we     = 1'b1;
            q_wdata  = {q_head, pi};
            p_re     = 1'b1;
            p_raddr  = q_tail;
            cur_in   = q_tail;
            state_in = S_APP_P;
         end

         S_APP_P: begin
            p_we     = 1'b1;
            p_waddr  = cur_ff;
            p_wdata  = {1'b1, pi, rd_tw};
            state_in = S_DONE;
         end

         // pop the head
         S_REL_Q: begin
            p_re     = 1'b1;
            p_raddr  = q_head;
            cur_in   = q_head;
            state_in = S_REL_P;
         end

         S_REL_P: begin
            if (!rd_nxv) begin
               nonempty_in[loc_ff] = 1'b0;
            end else begin
               q_we    = 1'b1;
               q_wdata = {rd_nx, q_tail};
            end
            p_we                 = 1'b1;
            p_waddr              = cur_ff;
            p_wdata              = {1'b0, {PW{1'b0}}, rd_tw};
            res_in.cancel_timer  = tw_valid_ff[cur_ff];
            tw_valid_in[cur_ff]  = 1'b0;
            res_in.ready_valid   = 1'b1;
            res_in.ready_process = 5'(cur_ff);
            state_in             = S_DONE;
         end

         // timeout cancel: find the lock, then walk its queue
         S_CAN_TW: begin
            loc_in = rd_tw;
            pnx_in = {rd_nxv, rd_nx};
            ptw_in = rd_tw;
            if (nonempty_ff[rd_tw]) begin
               q_re     = 1'b1;
               q_raddr  = rd_tw;
               state_in = S_CAN_Q;
            end else begin
               state_in = S_DONE;
            end
         end

         S_CAN_Q: begin
            if (q_head == pi) begin
               if (!pnx_ff[PW]) begin
                  nonempty_in[loc_ff] = 1'b0;
               end else begin
                  q_we    = 1'b1;
                  q_wdata = {pnx_ff[PW-1:0], q_tail};
               end
               p_we     = 1'b1;
               p_waddr  = pi;
               p_wdata  = {1'b0, {PW{1'b0}}, ptw_ff};
               state_in = S_DONE;
            end else begin
               cur_in   = q_head;
               steps_in = '0;
               p_re     = 1'b1;
               p_raddr  = q_head;
               state_in = S_CAN_WALK;
            end
         end

         S_CAN_WALK: begin
            if (!rd_nxv) begin
               state_in = S_DONE;
            end else if (rd_nx == pi) begin
               // bypass the cancelled process
               p_we    = 1'b1;
               p_waddr = cur_ff;
               p_wdata = {pnx_ff, rd_tw};
               if (q_tail == pi) begin
                  q_we    = 1'b1;
                  q_wdata = {q_head, cur_ff};
               end
               state_in = S_CAN_FIX;
            end else if (32'(steps_ff) == NUM_PROCS - 1) begin
               state_in = S_DONE;
            end else begin
               cur_in   = rd_nx;
               steps_in = steps_ff + 1'b1;
               p_re     = 1'b1;
               p_raddr  = rd_nx;
            end
         end

         S_CAN_FIX: begin
            p_we     = 1'b1;
            p_waddr  = pi;
            p_wdata  = {1'b0, {PW{1'b0}}, ptw_ff};
            state_in = S_DONE;
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_ff.status;
   assign rsp_bus.granted_lock  = rsp_ff.granted_lock;
   assign rsp_bus.ready_valid   = rsp_ff.ready_valid;
   assign rsp_bus.ready_process = rsp_ff.ready_process;
   assign rsp_bus.cancel_timer  = rsp_ff.cancel_timer;

   // a timeout always names the process it removed
   a_timeout_names_proc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_TIMED_OUT |-> rsp_ff.ready_valid)
      else $error("timed-out beat without ready process");

   // a dropped timer only comes with a successful pop
   a_cancel_with_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.cancel_timer |-> rsp_ff.ready_valid && rsp_ff.status == ST_OK)
      else $error("cancel_timer without popped waiter");

   // a finished result waits while the output beat is still held
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_bus.ready |=>
         state_ff == S_DONE && rsp_valid_ff)
      else $error("result overwrote a pending response beat");

endmodule

FILE: hw/rtl/lpq_find_free.sv
module lpq_find_free
   import lpq_pkg::*;
#(
   parameter int NUM_LOCKS = DEF_NUM_LOCKS,
   parameter int LW        = 4
) (
   input  logic [NUM_LOCKS-1:0] in_use,
   output logic                 found,
   output logic [LW-1:0]        index
);

   // lowest free lock wins
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
         if (!in_use[i]) begin
            found = 1'b1;
            index = LW'(i);
         end
      end
   end

endmodule
